// File: sv/assert_macros.svh
// Assertion macros of the cycle timer, included by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cycle timer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cycle timer assertion failed");

`endif

// File: sv/oct_pkg.sv
// Types, constants and helper functions of the on/off cycle timer.
`default_nettype none
package oct_pkg;

   localparam int SEC_W    = 15;
   localparam int TICK_W   = 32;
   localparam int REMAIN_W = 25;
   localparam int PERIOD_W = 26;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ON_SECONDS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_SECONDS = 2'd1;

   typedef struct packed {
      logic              operation;
      logic [TICK_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                changed;
      logic                relay_on;
      logic [REMAIN_W-1:0] remaining_ms;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] a;
      logic [TICK_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [TICK_W-1:0] diff;
      logic              borrow;
   } alu_rsp_type;

   // Seconds to milliseconds; zero counts as one second.
   function automatic logic [REMAIN_W-1:0] phase_ms(input logic [SEC_W-1:0] sec);
      logic [SEC_W-1:0]    s;
      logic [REMAIN_W-1:0] w;
      s = (sec == '0) ? SEC_W'(1) : sec;
      w = {10'b0, s};
      // 1000 = 1024 - 16 - 8
      return (w << 10) - (w << 4) - (w << 3);
   endfunction

endpackage
`default_nettype wire

// File: sv/oct_alu.sv
// Shared 32-bit subtract and compare unit of the cycle timer.
`default_nettype none
module oct_alu (
   input  oct_pkg::alu_req_type alu_req,
   output oct_pkg::alu_rsp_type alu_rsp
);
   import oct_pkg::*;

   logic [TICK_W:0] wide_diff;

   assign wide_diff      = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign alu_rsp.diff   = wide_diff[TICK_W-1:0];
   assign alu_rsp.borrow = wide_diff[TICK_W];

endmodule
`default_nettype wire

// File: sv/oct_seq.sv
// Sequencer and timer state: elapsed time, catch-up, period reduction.
`default_nettype none
module oct_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [oct_pkg::SEC_W-1:0] on_seconds,
   input  wire  [oct_pkg::SEC_W-1:0] off_seconds,
   input  wire                       req_fire,
   input  oct_pkg::req_type          req_data,
   output logic                      busy,
   input  wire                       out_free,
   output logic                      done,
   output oct_pkg::rsp_type          result
);
   import oct_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_LOOP = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int CNT_W = $clog2(TICK_W);

   logic [2:0]          state_ff, state_in;
   logic                phase_ff, phase_in;
   logic [REMAIN_W-1:0] tr_ff, tr_in;
   logic [TICK_W-1:0]   last_tick_ff, last_tick_in;
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                changed_ff, changed_in;

   logic [REMAIN_W-1:0] on_ms, off_ms;
   logic [PERIOD_W-1:0] period_sum;
   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;

   assign on_ms      = phase_ms(on_seconds);
   assign off_ms     = phase_ms(off_seconds);
   assign period_sum = {1'b0, on_ms} + {1'b0, off_ms};

   oct_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      tr_in        = tr_ff;
      last_tick_in = last_tick_ff;
      elapsed_in   = elapsed_ff;
      period_in    = period_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      changed_in   = changed_ff;
      alu_req.a    = '0;
      alu_req.b    = '0;
      done         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            alu_req.a = req_data.now_ms;
            alu_req.b = last_tick_ff;
            if (req_fire) begin
               last_tick_in = req_data.now_ms;
               changed_in   = 1'b0;
               if (req_data.operation == OP_START) begin
                  phase_in   = 1'b0;
                  tr_in      = off_ms;
                  elapsed_in = '0;
                  state_in   = ST_FIN;
               end else begin
                  elapsed_in = alu_rsp.diff;
                  state_in   = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            alu_req.a = elapsed_ff;
            alu_req.b = {{(TICK_W-REMAIN_W){1'b0}}, tr_ff};
            if (!alu_rsp.borrow) begin
               changed_in = 1'b1;
               elapsed_in = alu_rsp.diff;
               phase_in   = !phase_ff;
               tr_in      = phase_ff ? off_ms : on_ms;
               period_in  = period_sum;
               rem_in     = '0;
               cnt_in     = '1;
               state_in   = ST_MOD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MOD: begin
            // one remainder bit per cycle, dividend shifted in from the top
            alu_req.a = {{(TICK_W-PERIOD_W-1){1'b0}}, rem_ff, elapsed_ff[TICK_W-1]};
            alu_req.b = {{(TICK_W-PERIOD_W){1'b0}}, period_ff};
            rem_in     = alu_rsp.borrow ? alu_req.a[PERIOD_W-1:0]
                                        : alu_rsp.diff[PERIOD_W-1:0];
            elapsed_in = {elapsed_ff[TICK_W-2:0], 1'b0};
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               elapsed_in = {{(TICK_W-PERIOD_W){1'b0}}, rem_in};
               state_in   = ST_LOOP;
            end
         end
         ST_LOOP: begin
            alu_req.a = elapsed_ff;
            alu_req.b = {{(TICK_W-REMAIN_W){1'b0}}, tr_ff};
            if (!alu_rsp.borrow) begin
               elapsed_in = alu_rsp.diff;
               phase_in   = !phase_ff;
               tr_in      = phase_ff ? off_ms : on_ms;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            alu_req.a = {{(TICK_W-REMAIN_W){1'b0}}, tr_ff};
            alu_req.b = elapsed_ff;
            // hold until the output register can take the item
            if (out_free) begin
               tr_in    = alu_rsp.diff[REMAIN_W-1:0];
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ST_IDLE);
   assign result.changed      = changed_ff;
   assign result.relay_on     = phase_ff;
   assign result.remaining_ms = alu_rsp.diff[REMAIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         tr_ff        <= '0;
         last_tick_ff <= '0;
         changed_ff   <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         tr_ff        <= tr_in;
         last_tick_ff <= last_tick_in;
         changed_ff   <= changed_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      period_ff  <= period_in;
      rem_ff     <= rem_in;
   end

`include "assert_macros.svh"

   `OCT_ASSERT_NOW(a_rem_below_period, clock, reset, state_ff == ST_MOD, rem_ff < period_ff)
   `OCT_ASSERT_NOW(a_loop_below_period, clock, reset, state_ff == ST_LOOP,
      elapsed_ff < {{(TICK_W-PERIOD_W){1'b0}}, period_ff})
   `OCT_ASSERT_NOW(a_fin_no_underflow, clock, reset, state_ff == ST_FIN,
      elapsed_ff <= {{(TICK_W-REMAIN_W){1'b0}}, tr_ff})
   `OCT_ASSERT_NEXT(a_check_to_cmp, clock, reset,
      req_fire && req_data.operation == OP_CHECK, state_ff == ST_CMP)

endmodule
`default_nettype wire

// File: sv/on_off_cycle_timer_top.sv
// On/off cycle timer: relay phase timer with separate on and off durations.
//
// Channels: req_ carries one item (operation, now_ms); rsp_ returns one
// item (changed, relay_on, remaining_ms) for every request. An item moves
// at a rising edge where valid is high and stall is low. csr_ writes the
// on (index 0) and off (index 1) durations in seconds; csr_ready is always
// high, and writes are meant for times when no request is in flight.
// A start goes from idle to the finish state; a check passes the compare
// state first, and a check that toggles goes on through the remainder and
// loop states. The remainder is a 32-step restoring one against the
// on + off period, one bit per cycle through the shared subtractor.
// One request is worked at a time; req_stall is high while it is in work.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stalled receiver holds the last step until
// that register frees up. Reset (synchronous): relay off, remaining time 0,
// last tick 0, both durations 1 second.
`default_nettype none
module on_off_cycle_timer_top (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [oct_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [oct_pkg::SEC_W-1:0]     csr_data,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  oct_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output oct_pkg::rsp_type              rsp_data
);
   import oct_pkg::*;

   logic [SEC_W-1:0] on_s_ff, on_s_in;
   logic [SEC_W-1:0] off_s_ff, off_s_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic    busy, done, out_free, req_fire;
   rsp_type result;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      on_s_in  = on_s_ff;
      off_s_in = off_s_ff;
      if (csr_valid) begin
         if (csr_index == CSR_ON_SECONDS) begin
            on_s_in = csr_data;
         end else if (csr_index == CSR_OFF_SECONDS) begin
            off_s_in = csr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   oct_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .on_seconds  (on_s_ff),
      .off_seconds (off_s_ff),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .busy        (busy),
      .out_free    (out_free),
      .done        (done),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         on_s_ff      <= SEC_W'(1);
         off_s_ff     <= SEC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         on_s_ff      <= on_s_in;
         off_s_ff     <= off_s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb_on_off_cycle_timer_top.sv
// Self-checking testbench of the on/off cycle timer with random stimulus and idling.
`timescale 1ns / 100ps
module tb_on_off_cycle_timer_top;
   import oct_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SEC_W-1:0]     csr_data  = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;

   // tick items waiting for the driver, and relay reports still owed by the block
   req_type tick_items[$];
   rsp_type relay_reports[$];

   // shadow of the timer
   logic [SEC_W-1:0] on_sec  = SEC_W'(1);
   logic [SEC_W-1:0] off_sec = SEC_W'(1);
   logic             relay_st  = 1'b0;
   logic [31:0]      left_ms   = '0;
   logic [31:0]      tick_mark = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_left     = 0;
   logic        hold_arm      = 1'b0;
   logic [31:0] tick_now      = '0;

   on_off_cycle_timer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] sec_to_ms(input logic [SEC_W-1:0] sec);
      logic [31:0] s;
      s = (sec == '0) ? 32'd1 : 32'(sec);
      return s * 32'd1000;
   endfunction

   function automatic void flip_relay();
      relay_st = ~relay_st;
      left_ms  = relay_st ? sec_to_ms(on_sec) : sec_to_ms(off_sec);
   endfunction

   // Advance the shadow timer by one item and return the report it owes.
   function automatic rsp_type advance_relay(input req_type it);
      logic [31:0] span;
      logic        chg;
      rsp_type     rep;
      chg = 1'b0;
      if (it.operation == OP_START) begin
         tick_mark = it.now_ms;
         relay_st  = 1'b0;
         left_ms   = sec_to_ms(off_sec);
      end else begin
         span      = it.now_ms - tick_mark;
         tick_mark = it.now_ms;
         if (left_ms <= span) begin
            chg  = 1'b1;
            span = span - left_ms;
            flip_relay();
            // drop whole on + off periods at once
            span = span % (sec_to_ms(on_sec) + sec_to_ms(off_sec));
            while (left_ms <= span) begin
               span = span - left_ms;
               flip_relay();
            end
         end
         left_ms = left_ms - span;
      end
      rep.changed      = chg;
      rep.relay_on     = relay_st;
      rep.remaining_ms = left_ms[REMAIN_W-1:0];
      return rep;
   endfunction

   // Driver: offer queued tick items, hold a stalled one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            relay_reports.push_back(advance_relay(req_data));
         end
         if (!(req_valid && req_stall)) begin
            if (tick_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= tick_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted report and drive the receiver stall.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (relay_reports.size() == 0) begin
               $error("report with no item pending: %p", rsp_data);
               fail_count++;
            end else begin
               want = relay_reports.pop_front();
               if (rsp_data.changed !== want.changed) begin
                  $error("changed: expected %0d, got %0d", want.changed, rsp_data.changed);
                  fail_count++;
               end
               if (rsp_data.relay_on !== want.relay_on) begin
                  $error("relay_on: expected %0d, got %0d", want.relay_on, rsp_data.relay_on);
                  fail_count++;
               end
               if (rsp_data.remaining_ms !== want.remaining_ms) begin
                  $error("remaining_ms: expected %0d, got %0d",
                         want.remaining_ms, rsp_data.remaining_ms);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_arm) begin
            // hold off long enough for the block to back up into its input
            hold_arm  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(input logic op, input logic [31:0] now);
      tick_items.push_back(req_type'{operation: op, now_ms: now});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_items.size() != 0 || req_valid || relay_reports.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SEC_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ON_SECONDS) on_sec = val;
      else off_sec = val;
   endtask

   task automatic set_timer(input logic [SEC_W-1:0] on_s, input logic [SEC_W-1:0] off_s);
      wait_drained();
      csr_write(CSR_ON_SECONDS, on_s);
      csr_write(CSR_OFF_SECONDS, off_s);
   endtask

   // Mostly checks at whole-second steps, with restarts, short steps and wild jumps.
   task automatic random_run(input int count);
      int unsigned span_s;
      int unsigned pick;
      logic [31:0] delta;
      span_s = 2 * ((sec_to_ms(on_sec) + sec_to_ms(off_sec)) / 1000);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            tick_now = tick_now + $urandom_range(0, 5000);
            push_item(OP_START, tick_now);
         end else if (pick < 8) begin
            tick_now = $urandom();
            push_item(OP_START, tick_now);
         end else begin
            if (pick < 50) delta = $urandom_range(0, span_s) * 1000 + $urandom_range(0, 2) - 1;
            else if (pick < 75) delta = $urandom_range(0, span_s * 1000);
            else if (pick < 90) delta = $urandom_range(0, 999);
            else delta = $urandom();
            tick_now = tick_now + delta;
            push_item(OP_CHECK, tick_now);
         end
      end
   endtask

   initial begin
      send_idle_pct = 29;
      recv_idle_pct = 63;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset durations; check before any start toggles to on
      push_item(OP_CHECK, 32'h0000_0000);
      push_item(OP_CHECK, 32'h0000_0000);
      push_item(OP_CHECK, 32'd999);
      push_item(OP_CHECK, 32'd1000);
      push_item(OP_START, 32'hFFFF_FFFF);
      push_item(OP_CHECK, 32'd999);
      push_item(OP_CHECK, 32'h7FFF_FFFF);
      push_item(OP_START, 32'h0000_0000);
      push_item(OP_CHECK, 32'hFFFF_FFFF);
      tick_now = 32'hFFFF_FFFF;
      random_run(110);

      set_timer(SEC_W'(32767), SEC_W'(32767));
      tick_now = 32'h1234_5678;
      push_item(OP_START, tick_now);
      tick_now = tick_now + 32'd32766999;
      push_item(OP_CHECK, tick_now);
      tick_now = tick_now + 32'd1;
      push_item(OP_CHECK, tick_now);
      tick_now = tick_now + 32'd196602005;
      push_item(OP_CHECK, tick_now);
      random_run(110);

      wait_drained();
      send_idle_pct = 63;
      recv_idle_pct = 29;
      set_timer(SEC_W'(1), SEC_W'(32767));
      random_run(150);
      // change durations while running: the loaded time stays
      set_timer(SEC_W'(32767), SEC_W'(1));
      random_run(150);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // zero durations count as one second
      set_timer('0, '0);
      push_item(OP_START, tick_now);
      tick_now = tick_now + 32'd1000;
      push_item(OP_CHECK, tick_now);
      tick_now = tick_now + 32'd10000;
      push_item(OP_CHECK, tick_now);
      random_run(80);

      set_timer(SEC_W'($urandom_range(1, 5)), SEC_W'($urandom_range(1, 5)));
      hold_arm = 1'b1;
      random_run(100);

      set_timer(SEC_W'($urandom_range(1, 32767)), SEC_W'($urandom_range(1, 32767)));
      random_run(80);

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && relay_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
